[src/maf_pkg.sv]
package maf_pkg;

	// Sizing
	localparam int WINDOW_MAX = 64;
	localparam int SAMPLE_W   = 16;
	localparam int WSIZE_W    = 7;
	localparam int ALPHA_W    = 16;
	localparam int WIN_W      = $clog2(WINDOW_MAX + 1);
	localparam int POS_W      = $clog2(WINDOW_MAX);
	localparam int SUM_W      = SAMPLE_W + POS_W;
	localparam int VAL_W      = 32;
	localparam int CNT_W      = $clog2(SUM_W + 1);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	// Register map
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;
	localparam logic [1:0] REG_ALPHA  = 2'd2;

	// Filter modes
	localparam logic MODE_MA   = 1'b0;
	localparam logic MODE_EWMA = 1'b1;

	// Register reset values
	localparam logic [WSIZE_W-1:0] WINDOW_RESET = 7'd8;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 16'd8192;

	typedef enum logic [1:0] {
		F_IDLE,
		F_EXEC,
		F_FIN
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_OUT
	} back_state_t;

	// One job handed from the front to the back
	typedef struct packed {
		logic             mode;
		logic [VAL_W-1:0] val;
		logic [WIN_W-1:0] win;
	} job_t;

	// Clamp the window register into 1 .. WINDOW_MAX
	function automatic logic [WIN_W-1:0] eff_window(input logic [WSIZE_W-1:0] ws);
		logic [WIN_W-1:0] w;
		if (ws == '0)
			w = WIN_W'(1);
		else if (int'(ws) > WINDOW_MAX)
			w = WIN_W'(WINDOW_MAX);
		else
			w = WIN_W'(ws);
		return w;
	endfunction

endpackage

[src/maf_queue.sv]
module maf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  maf_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output maf_pkg::job_t pop_job,
	output logic          empty
);
	import maf_pkg::*;

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = slot_q[rd_ptr_q];

	// Store requests
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_job;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[src/maf_front.sv]
module maf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  logic                           cfg_mode,
	input  logic [maf_pkg::WSIZE_W-1:0]    cfg_window,
	input  logic [maf_pkg::ALPHA_W-1:0]    cfg_alpha,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [maf_pkg::SAMPLE_W-1:0] in_sample,
	output logic                           push,
	output maf_pkg::job_t                  push_job,
	input  logic                           q_full
);
	import maf_pkg::*;

	localparam int P1_W  = ALPHA_W + 1 + SAMPLE_W;
	localparam int OM_W  = ALPHA_W + 1;
	localparam int P2_W  = OM_W + 1 + VAL_W;
	localparam int ACC_W = P2_W;

	front_state_t             state_q, state_d;
	logic [WIN_W-1:0]         win;
	logic [POS_W-1:0]         pos_eff;
	logic [POS_W-1:0]         pos_next;
	logic                     accept;

	logic signed [SAMPLE_W-1:0] ring [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]      valid_q;
	logic [POS_W-1:0]           pos_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [VAL_W-1:0]    prev_q;

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic [POS_W-1:0]           wp_q;
	logic                       mode_q;
	logic signed [P1_W-1:0]     p1_q;
	logic signed [P2_W-1:0]     p2_q;

	logic signed [SAMPLE_W-1:0] old_sample;
	logic signed [SUM_W-1:0]    sum_n;
	logic [OM_W-1:0]            one_minus;
	logic signed [ACC_W-1:0]    acc;
	logic signed [VAL_W-1:0]    prev_n;

	assign win      = eff_window(cfg_window);
	assign pos_eff  = (int'(pos_q) >= int'(win)) ? '0 : pos_q;
	assign pos_next = (int'(wp_q) + 1 >= int'(win)) ? '0 : wp_q + 1'b1;
	assign in_ready = (state_q == F_IDLE) && !q_full;
	assign accept   = in_valid && in_ready;

	// Moving-average update: drop the oldest sample, add the new one
	assign old_sample = valid_q[wp_q] ? rd_q : '0;
	assign sum_n      = sum_q - SUM_W'(old_sample) + SUM_W'(x_q);

	// Exponential update: weigh new sample and previous output, floor to Q16.16
	assign one_minus = OM_W'(17'h10000 - {1'b0, cfg_alpha});
	assign acc       = (ACC_W'(p1_q) <<< 16) + ACC_W'(p2_q);
	assign prev_n    = acc[VAL_W+15:16];

	// Next state and request to the queue
	always_comb begin
		state_d  = state_q;
		push     = 1'b0;
		push_job = '{mode: mode_q, val: '0, win: win};
		case (state_q)
			F_IDLE: begin
				if (accept)
					state_d = F_EXEC;
			end
			F_EXEC: begin
				if (mode_q == MODE_MA) begin
					push         = 1'b1;
					push_job.val = VAL_W'(sum_n);
					state_d      = F_IDLE;
				end else begin
					state_d = F_FIN;
				end
			end
			F_FIN: begin
				push         = 1'b1;
				push_job.val = prev_n;
				state_d      = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	// Sample ring: read at accept, write back the new sample
	always_ff @(posedge clk) begin
		if (accept)
			rd_q <= ring[pos_eff];
		if (state_q == F_EXEC && mode_q == MODE_MA)
			ring[wp_q] <= x_q;
	end

	// Hold the request and the products
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= in_sample;
			wp_q   <= pos_eff;
			mode_q <= cfg_mode;
		end
		if (state_q == F_EXEC && mode_q == MODE_EWMA) begin
			p1_q <= $signed({1'b0, cfg_alpha}) * x_q;
			p2_q <= $signed({1'b0, one_minus}) * prev_q;
		end
	end

	// Filter state, cleared on reset and on any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
			prev_q  <= '0;
		end else if (clear) begin
			valid_q <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
			prev_q  <= '0;
		end else begin
			if (state_q == F_EXEC && mode_q == MODE_MA) begin
				valid_q[wp_q] <= 1'b1;
				pos_q         <= pos_next;
				sum_q         <= sum_n;
			end
			if (state_q == F_FIN)
				prev_q <= prev_n;
		end
	end

endmodule

[src/maf_back.sv]
module maf_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  maf_pkg::job_t                  q_job,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [maf_pkg::SAMPLE_W-1:0]   out_data
);
	import maf_pkg::*;

	back_state_t          state_q, state_d;
	logic                 mode_q;
	logic                 neg_q;
	logic [SUM_W-1:0]     dq_q;
	logic [WIN_W-1:0]     rem_q;
	logic [WIN_W-1:0]     win_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SAMPLE_W-1:0]  hi_q;
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  out_data_q;

	logic [SUM_W-1:0]     sum_in;
	logic [SUM_W-1:0]     mag_in;
	logic [WIN_W:0]       rem_sh;
	logic [WIN_W:0]       rem_sub;
	logic                 q_bit;
	logic [SUM_W-1:0]     quo_signed;
	logic                 out_free;
	logic                 load_out;
	logic                 last_step;

	assign sum_in  = q_job.val[SUM_W-1:0];
	assign mag_in  = sum_in[SUM_W-1] ? (~sum_in + 1'b1) : sum_in;

	// One quotient bit per cycle
	assign rem_sh  = {rem_q, dq_q[SUM_W-1]};
	assign q_bit   = (rem_sh >= {1'b0, win_q});
	assign rem_sub = rem_sh - {1'b0, win_q};

	assign quo_signed = neg_q ? (~dq_q + 1'b1) : dq_q;
	assign last_step  = (cnt_q == CNT_W'(SUM_W - 1));
	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = (q_job.mode == MODE_MA) ? B_DIV : B_OUT;
				end
			end
			B_DIV: begin
				if (last_step)
					state_d = B_OUT;
			end
			B_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	// Load a job and run the divider
	always_ff @(posedge clk) begin
		if (pop) begin
			mode_q <= q_job.mode;
			neg_q  <= sum_in[SUM_W-1];
			dq_q   <= mag_in;
			rem_q  <= '0;
			win_q  <= q_job.win;
			cnt_q  <= '0;
			hi_q   <= q_job.val[VAL_W-1:VAL_W-SAMPLE_W];
		end else if (state_q == B_DIV) begin
			dq_q  <= {dq_q[SUM_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_out)
			out_data_q <= (mode_q == MODE_MA) ? quo_signed[SAMPLE_W-1:0] : hi_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

endmodule

[src/moving_average_or_ewma_filter.sv]
// Moving-average / exponential smoothing filter.
// Samples enter on the s_ stream and one filtered sample leaves on the
// m_ stream for each. Registers sit behind an APB port: filter_mode at 0x0,
// window_size at 0x4, alpha at 0x8; pready is always high. Any register write
// clears the sample ring, running sum and previous output; write only when
// the block is idle.
// The front accepts a sample only while idle and the queue is not full; it
// updates the filter state and queues a job in its exec state (moving
// average) or forms the products in exec and does so in fin (exponential).
// The back divides the running sum by the window with a bit-serial divider,
// one quotient bit per cycle; a moving-average item goes through pop, the
// divider steps and the output load, and the divider sets the sustained rate.
// An exponential item skips the divider and goes from pop to the output load.
// The result sits in an output register; while m_tready is low it holds, the
// two-entry job queue fills and then s_tready drops.
// Reset clears the state, the ring's valid bits and all handshakes, and
// loads the register defaults (moving average, window 8, alpha 8192).
module moving_average_or_ewma_filter (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: sample [15:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	// m_tdata: filtered [15:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import maf_pkg::*;

	logic               mode_q;
	logic [WSIZE_W-1:0] window_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic               wr_en;
	logic [1:0]         reg_idx;
	logic               clear;

	logic               push;
	job_t               push_job;
	logic               q_full;
	logic               pop;
	job_t               pop_job;
	logic               q_empty;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign clear   = wr_en && (reg_idx == REG_MODE || reg_idx == REG_WINDOW ||
	                           reg_idx == REG_ALPHA);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_MA;
			window_q <= WINDOW_RESET;
			alpha_q  <= ALPHA_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:   mode_q   <= pwdata[0];
				REG_WINDOW: window_q <= pwdata[WSIZE_W-1:0];
				REG_ALPHA:  alpha_q  <= pwdata[ALPHA_W-1:0];
				default:    ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			REG_MODE:   prdata = {31'b0, mode_q};
			REG_WINDOW: prdata = {{(32-WSIZE_W){1'b0}}, window_q};
			REG_ALPHA:  prdata = {{(32-ALPHA_W){1'b0}}, alpha_q};
			default:    prdata = '0;
		endcase
	end

	maf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (clear),
		.cfg_mode   (mode_q),
		.cfg_window (window_q),
		.cfg_alpha  (alpha_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_sample  (s_tdata),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	maf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	maf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_job     (pop_job),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
